// ===== rtl/core/ffha_pkg.sv =====
// Shared types, codes and defaults for the first-fit heap allocator.
package ffha_pkg;

   localparam int DEF_HEAP_BYTES    = 16384;
   localparam int DEF_GRANULE_BYTES = 16;
   localparam int DEF_MAX_EXTENTS   = 512;

   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_REINIT = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_LOAD      = 5'd1;
   localparam logic [4:0] OP_READ      = 5'd3;
   localparam logic [4:0] OP_NEXT      = 5'd4;
   localparam logic [4:0] OP_ASPLIT    = 5'd5;
   localparam logic [4:0] OP_AEXACT    = 5'd6;
   localparam logic [4:0] OP_RM_RD     = 5'd7;
   localparam logic [4:0] OP_RM_WR     = 5'd8;
   localparam logic [4:0] OP_DEC       = 5'd9;
   localparam logic [4:0] OP_MBOTH     = 5'd10;
   localparam logic [4:0] OP_MPREV     = 5'd11;
   localparam logic [4:0] OP_MSUCC     = 5'd12;
   localparam logic [4:0] OP_INS_START = 5'd13;
   localparam logic [4:0] OP_IN_RD     = 5'd14;
   localparam logic [4:0] OP_IN_WR     = 5'd15;
   localparam logic [4:0] OP_INS_FIN   = 5'd16;
   localparam logic [4:0] OP_REINIT    = 5'd17;
   localparam logic [4:0] OP_RESP      = 5'd18;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] st;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       asz0;
      logic       bad_arg;
      logic       in_range;
      logic       fit;
      logic       exact;
      logic       go_on;
      logic       inv_ovl;
      logic       mp;
      logic       ms;
      logic       full;
      logic       rm_more;
      logic       in_more;
   } stat_type;

endpackage

// ===== rtl/core/ffha_ctrl.sv =====
// Sequencing state machine of the heap allocator.
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd3;
   localparam logic [3:0] S_ARD  = 4'd4;
   localparam logic [3:0] S_ACHK = 4'd5;
   localparam logic [3:0] S_FRD  = 4'd6;
   localparam logic [3:0] S_FCHK = 4'd7;
   localparam logic [3:0] S_FEVL = 4'd8;
   localparam logic [3:0] S_RMRD = 4'd9;
   localparam logic [3:0] S_RMWR = 4'd10;
   localparam logic [3:0] S_INRD = 4'd11;
   localparam logic [3:0] S_INWR = 4'd12;
   localparam logic [3:0] S_RESP = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd.op   = OP_NONE;
      cmd.st   = st_ff;
      case (state_ff)
         S_INIT: begin
            cmd.op   = OP_REINIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            st_in    = ST_INVALID;
            state_in = S_RESP;
            case (stat.kind)
               KIND_ALLOC: begin
                  if (!stat.asz0) state_in = S_ARD;
               end
               KIND_FREE: begin
                  if (!stat.bad_arg) state_in = S_FRD;
               end
               KIND_REINIT: begin
                  cmd.op = OP_REINIT;
                  st_in  = ST_OK;
               end
               default: st_in = ST_INVALID;
            endcase
         end
         S_ARD: begin
            if (stat.in_range) begin
               cmd.op   = OP_READ;
               state_in = S_ACHK;
            end else begin
               st_in    = ST_NOFIT;
               state_in = S_RESP;
            end
         end
         S_ACHK: begin
            st_in = ST_OK;
            if (stat.fit && stat.exact) begin
               cmd.op   = OP_AEXACT;
               state_in = S_RMRD;
            end else if (stat.fit) begin
               cmd.op   = OP_ASPLIT;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_NEXT;
               state_in = S_ARD;
            end
         end
         S_FRD: begin
            if (stat.in_range) begin
               cmd.op   = OP_READ;
               state_in = S_FCHK;
            end else begin
               state_in = S_FEVL;
            end
         end
         S_FCHK: begin
            if (stat.go_on) begin
               cmd.op   = OP_NEXT;
               state_in = S_FRD;
            end else begin
               state_in = S_FEVL;
            end
         end
         S_FEVL: begin
            st_in    = ST_OK;
            state_in = S_RESP;
            if (stat.inv_ovl) begin
               st_in = ST_INVALID;
            end else if (stat.mp && stat.ms) begin
               cmd.op   = OP_MBOTH;
               state_in = S_RMRD;
            end else if (stat.mp) begin
               cmd.op = OP_MPREV;
            end else if (stat.ms) begin
               cmd.op = OP_MSUCC;
            end else if (stat.full) begin
               st_in = ST_INVALID;
            end else begin
               cmd.op   = OP_INS_START;
               state_in = S_INRD;
            end
         end
         S_RMRD: begin
            if (stat.rm_more) begin
               cmd.op   = OP_RM_RD;
               state_in = S_RMWR;
            end else begin
               cmd.op   = OP_DEC;
               state_in = S_RESP;
            end
         end
         S_RMWR: begin
            cmd.op   = OP_RM_WR;
            state_in = S_RMRD;
         end
         S_INRD: begin
            if (stat.in_more) begin
               cmd.op   = OP_IN_RD;
               state_in = S_INWR;
            end else begin
               cmd.op   = OP_INS_FIN;
               state_in = S_RESP;
            end
         end
         S_INWR: begin
            cmd.op   = OP_IN_WR;
            state_in = S_INRD;
         end
         S_RESP: begin
            cmd.op   = OP_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/ffha_dpath.sv =====
// Datapath of the heap allocator: granule scaling, extent memory, pointers, result.
module ffha_dpath
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES    = DEF_HEAP_BYTES,
   parameter int GRANULE_BYTES = DEF_GRANULE_BYTES,
   parameter int MAX_EXTENTS   = DEF_MAX_EXTENTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_kind,
   input  logic [14:0] req_size_bytes,
   input  logic [13:0] req_offset,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_granted_offset
);

   localparam int HEAP_G = HEAP_BYTES / GRANULE_BYTES;
   localparam int GW     = $clog2(HEAP_G + 1);
   // size plus rounding fits 16 bits
   localparam int SW     = 16;
   localparam int AW     = ((GW > SW) ? GW : SW) + 1;
   localparam int IW     = $clog2(MAX_EXTENTS);
   localparam int CW     = $clog2(MAX_EXTENTS + 1);
   localparam int GSH    = $clog2(GRANULE_BYTES);
   localparam int PW     = (GW + 7 > 14) ? GW + 7 : 14;

   logic [GW-1:0] st_mem [MAX_EXTENTS];
   logic [GW-1:0] ln_mem [MAX_EXTENTS];

   logic [1:0]       kind_ff;
   logic [14:0]      size_ff;
   logic [SW-1:0]    qn_ff, qo_ff;
   logic [GSH-1:0]   ro_ff;
   logic [CW-1:0]    count_ff, count_in, idx_ff, idx_in, k_ff, k_in;
   logic [GW-1:0]    prev_st_ff, prev_st_in, prev_ln_ff, prev_ln_in;
   logic [GW-1:0]    rdst_ff, rdln_ff;
   logic [13:0]      grant_ff, grant_in;
   logic             strobe_ff;
   logic [1:0]       status_ff;
   logic [13:0]      gout_ff;

   logic             we, re;
   logic [CW-1:0]    wa, ra;
   logic [GW-1:0]    wst, wln;
   logic [AW-1:0]    a_s, a_n, a_rs, a_rl, a_pe, a_sn;
   logic [PW-1:0]    prod;

   // granule is a power of two: round-up shift for the size, shift and mask for the offset
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         kind_ff <= req_kind;
         size_ff <= req_size_bytes;
         qn_ff   <= SW'((SW'(req_size_bytes) + SW'(GRANULE_BYTES - 1)) >> GSH);
         qo_ff   <= SW'(req_offset >> GSH);
         ro_ff   <= req_offset[GSH-1:0];
      end
   end

   assign a_s  = AW'(qo_ff);
   assign a_n  = AW'(qn_ff);
   assign a_rs = AW'(rdst_ff);
   assign a_rl = AW'(rdln_ff);
   assign a_pe = AW'(prev_st_ff) + AW'(prev_ln_ff);
   assign a_sn = a_s + a_n;
   assign prod = PW'(rdst_ff) * PW'(GRANULE_BYTES);

   always_comb begin
      stat.kind     = kind_ff;
      stat.asz0     = (size_ff == '0);
      stat.bad_arg  = (size_ff == '0) || (ro_ff != '0) || (a_sn > AW'(HEAP_G));
      stat.in_range = (idx_ff < count_ff);
      stat.fit      = (a_rl >= a_n);
      stat.exact    = (a_rl == a_n);
      stat.go_on    = (a_rs <= a_s);
      stat.inv_ovl  = ((idx_ff != '0) && (a_pe > a_s)) ||
                      ((idx_ff < count_ff) && (a_sn > a_rs));
      stat.mp       = (idx_ff != '0) && (a_pe == a_s);
      stat.ms       = (idx_ff < count_ff) && (a_sn == a_rs);
      stat.full     = (count_ff >= CW'(MAX_EXTENTS));
      stat.rm_more  = ((k_ff + 1'b1) < count_ff);
      stat.in_more  = (k_ff > idx_ff);
   end

   always_comb begin
      we         = 1'b0;
      re         = 1'b0;
      wa         = idx_ff;
      ra         = idx_ff;
      wst        = rdst_ff;
      wln        = rdln_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      prev_st_in = prev_st_ff;
      prev_ln_in = prev_ln_ff;
      grant_in   = grant_ff;
      case (cmd.op)
         OP_LOAD: begin
            idx_in   = '0;
            grant_in = '0;
         end
         OP_READ: re = 1'b1;
         OP_NEXT: begin
            prev_st_in = rdst_ff;
            prev_ln_in = rdln_ff;
            idx_in     = idx_ff + 1'b1;
         end
         OP_ASPLIT: begin
            we       = 1'b1;
            wst      = GW'(a_rs + a_n);
            wln      = GW'(a_rl - a_n);
            grant_in = prod[13:0];
         end
         OP_AEXACT: begin
            k_in     = idx_ff;
            grant_in = prod[13:0];
         end
         OP_RM_RD: begin
            re = 1'b1;
            ra = k_ff + 1'b1;
         end
         OP_RM_WR: begin
            we   = 1'b1;
            wa   = k_ff;
            k_in = k_ff + 1'b1;
         end
         OP_DEC: count_in = count_ff - 1'b1;
         OP_MBOTH: begin
            we   = 1'b1;
            wa   = idx_ff - 1'b1;
            wst  = prev_st_ff;
            wln  = GW'(a_pe - AW'(prev_st_ff) + a_n + a_rl);
            k_in = idx_ff;
         end
         OP_MPREV: begin
            we  = 1'b1;
            wa  = idx_ff - 1'b1;
            wst = prev_st_ff;
            wln = GW'(AW'(prev_ln_ff) + a_n);
         end
         OP_MSUCC: begin
            we  = 1'b1;
            wst = GW'(a_s);
            wln = GW'(a_rl + a_n);
         end
         OP_INS_START: k_in = count_ff;
         OP_IN_RD: begin
            re = 1'b1;
            ra = k_ff - 1'b1;
         end
         OP_IN_WR: begin
            we   = 1'b1;
            wa   = k_ff;
            k_in = k_ff - 1'b1;
         end
         OP_INS_FIN: begin
            we       = 1'b1;
            wst      = GW'(a_s);
            wln      = GW'(a_n);
            count_in = count_ff + 1'b1;
         end
         OP_REINIT: begin
            we       = 1'b1;
            wa       = '0;
            wst      = '0;
            wln      = GW'(HEAP_G);
            count_in = CW'(1);
         end
         default: ;
      endcase
   end

   // extent table, single write port and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         st_mem[wa[IW-1:0]] <= wst;
         ln_mem[wa[IW-1:0]] <= wln;
      end
      if (re) begin
         rdst_ff <= st_mem[ra[IW-1:0]];
         rdln_ff <= ln_mem[ra[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      prev_st_ff <= prev_st_in;
      prev_ln_ff <= prev_ln_in;
      grant_ff   <= grant_in;
      if (cmd.op == OP_RESP) begin
         status_ff <= cmd.st;
         gout_ff   <= grant_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CW'(1);
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= (cmd.op == OP_RESP);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_offset = gout_ff;

endmodule

// ===== rtl/core/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator with coalescing free list.
//
//  channel   ports                                         handshake
//  request   req_kind, req_size_bytes, req_offset          start & !busy
//  result    rsp_status, rsp_granted_offset                rsp_strobe, one cycle
//
//  Items are taken one at a time while busy is low; the time per item grows with
//  each extent scanned and each entry shifted on insert or removal, since the
//  extent memory has a single read port.
//  After reset busy stays high while entry 0 is written.
//  The strobe comes in the first cycle with busy low; the receiver cannot stall.
module first_fit_heap_allocator_unit
   import ffha_pkg::*;
#(
   parameter int HEAP_BYTES    = DEF_HEAP_BYTES,
   parameter int GRANULE_BYTES = DEF_GRANULE_BYTES,
   parameter int MAX_EXTENTS   = DEF_MAX_EXTENTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [14:0] req_size_bytes,
   input  logic [13:0] req_offset,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_granted_offset
);

   cmd_type  cmd;
   stat_type stat;

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffha_dpath #(
      .HEAP_BYTES    (HEAP_BYTES),
      .GRANULE_BYTES (GRANULE_BYTES),
      .MAX_EXTENTS   (MAX_EXTENTS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_size_bytes     (req_size_bytes),
      .req_offset         (req_offset),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result repeated");
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_granted_offset == 14'd0)
      else $error("offset on failed item");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the first-fit heap allocator unit.
`timescale 1ns / 100ps

module tb
   import ffha_pkg::*;
;

   localparam int HEAP_GR    = DEF_HEAP_BYTES / DEF_GRANULE_BYTES;
   localparam int GR         = DEF_GRANULE_BYTES;
   localparam int MAXEXT     = DEF_MAX_EXTENTS;
   localparam int CYCLE_LIMIT = 40000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_ALLOC;
   logic [14:0] req_size_bytes = '0;
   logic [13:0] req_offset = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_granted_offset;

   first_fit_heap_allocator_unit u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor's copy of the free table
   int unsigned fx_start[MAXEXT];
   int unsigned fx_len[MAXEXT];
   int unsigned fx_count;

   typedef struct {
      logic [1:0]  status;
      logic [13:0] grant;
   } alloc_result_type;

   alloc_result_type pending_results[$];
   int unsigned   mismatches = 0;
   int unsigned   cycles = 0;
   // live allocations, used to build sensible frees
   int unsigned   live_off[$];
   int unsigned   live_size[$];

   function automatic void heap_reinit();
      fx_start[0] = 0;
      fx_len[0] = HEAP_GR;
      fx_count = 1;
   endfunction

   function automatic void drop_extent(int unsigned i);
      for (int unsigned k = i; k + 1 < fx_count; k++) begin
         fx_start[k] = fx_start[k + 1];
         fx_len[k] = fx_len[k + 1];
      end
      fx_count--;
   endfunction

   function automatic alloc_result_type predict_heap(logic [1:0] kind, logic [14:0] size,
                                                     logic [13:0] off);
      alloc_result_type r;
      int unsigned n, s, p;
      bit mp, ms;
      r.status = ST_INVALID;
      r.grant = '0;
      n = (int'(size) + GR - 1) / GR;
      if (kind == KIND_ALLOC) begin
         if (size == 0) return r;
         r.status = ST_NOFIT;
         for (int unsigned i = 0; i < fx_count; i++) begin
            if (fx_len[i] >= n) begin
               r.status = ST_OK;
               r.grant = 14'(fx_start[i] * GR);
               if (fx_len[i] == n) drop_extent(i);
               else begin
                  fx_start[i] += n;
                  fx_len[i] -= n;
               end
               return r;
            end
         end
      end else if (kind == KIND_FREE) begin
         if (size == 0 || (off % GR) != 0) return r;
         s = off / GR;
         if (s + n > HEAP_GR) return r;
         p = 0;
         while (p < fx_count && fx_start[p] <= s) p++;
         if (p > 0 && fx_start[p - 1] + fx_len[p - 1] > s) return r;
         if (p < fx_count && s + n > fx_start[p]) return r;
         mp = p > 0 && fx_start[p - 1] + fx_len[p - 1] == s;
         ms = p < fx_count && s + n == fx_start[p];
         if (mp && ms) begin
            fx_len[p - 1] += n + fx_len[p];
            drop_extent(p);
         end else if (mp) fx_len[p - 1] += n;
         else if (ms) begin
            fx_start[p] = s;
            fx_len[p] += n;
         end else begin
            if (fx_count >= MAXEXT) return r;
            for (int unsigned k = fx_count; k > p; k--) begin
               fx_start[k] = fx_start[k - 1];
               fx_len[k] = fx_len[k - 1];
            end
            fx_start[p] = s;
            fx_len[p] = n;
            fx_count++;
         end
         r.status = ST_OK;
      end else if (kind == KIND_REINIT) begin
         heap_reinit();
         r.status = ST_OK;
      end
      return r;
   endfunction

   // send one item after a random gap; inputs move on the falling edge
   task automatic send_request(logic [1:0] kind, logic [14:0] size, logic [13:0] off,
                               bit no_gap = 1'b0);
      alloc_result_type r;
      int unsigned gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16));
      repeat (gap) @(negedge clock);
      req_kind = kind;
      req_size_bytes = size;
      req_offset = off;
      start = 1'b1;
      do @(posedge clock); while (busy);
      r = predict_heap(kind, size, off);
      pending_results.push_back(r);
      if (kind == KIND_ALLOC && r.status == ST_OK) begin
         live_off.push_back(r.grant);
         live_size.push_back(size);
      end
      if (kind == KIND_REINIT) begin
         live_off.delete();
         live_size.delete();
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      alloc_result_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d", rsp_status);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_granted_offset !== e.grant) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d off=%0d got st=%0d off=%0d",
                           e.status, e.grant, rsp_status, rsp_granted_offset);
            end
         end
      end
   end

   task automatic test_directed();
      send_request(KIND_ALLOC, 15'd0, 14'd0);         // zero-size allocate
      send_request(KIND_ALLOC, 15'd16384, 14'd0);     // whole heap
      send_request(KIND_ALLOC, 15'd1, 14'd0);         // empty table
      send_request(KIND_FREE, 15'd16384, 14'd0);
      send_request(KIND_ALLOC, 15'd17, 14'd0);
      send_request(KIND_ALLOC, 15'd32, 14'd0);
      send_request(KIND_ALLOC, 15'd48, 14'd0);
      send_request(KIND_FREE, 15'd32, 14'd32);        // middle hole
      send_request(KIND_FREE, 15'd32, 14'd32);        // overlap
      send_request(KIND_FREE, 15'd0, 14'd64);         // zero-size free
      send_request(KIND_FREE, 15'd16, 14'd7);         // misaligned
      send_request(KIND_FREE, 15'd32, 14'd16368);     // beyond heap end
      send_request(KIND_FREE, 15'h7fff, 14'h3fff);
      send_request(KIND_FREE, 15'd32, 14'd0);         // merge with successor
      send_request(KIND_FREE, 15'd48, 14'd64);        // merge both sides
      send_request(KIND_ALLOC, 15'h7fff, 14'h3fff);   // no fit
      send_request(2'd3, 15'h7fff, 14'h3fff);         // unknown kind
      send_request(KIND_REINIT, 15'd5, 14'd5);
      send_request(KIND_ALLOC, 15'd16385, 14'd0);
      wait_drained();
   endtask

   // fill the table to capacity: 1024 granules, alternate allocations freed
   task automatic test_table_full();
      send_request(KIND_REINIT, 15'd0, 14'd0);
      for (int i = 0; i < HEAP_GR; i++) send_request(KIND_ALLOC, 15'd16, 14'd0, 1'b1);
      for (int i = 0; i < HEAP_GR; i += 2) send_request(KIND_FREE, 15'd16, 14'(i * GR), 1'b1);
      send_request(KIND_FREE, 15'd16, 14'd16);        // merges both, still fine
      send_request(KIND_REINIT, 15'd0, 14'd0);
      wait_drained();
   endtask

   task automatic test_random(int unsigned count);
      int unsigned sel, idx;
      logic [14:0] sz;
      for (int unsigned i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            sz = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(1, 600));
            send_request(KIND_ALLOC, sz, 14'($urandom));
         end else if (sel < 85 && live_off.size() != 0) begin
            idx = $urandom_range(0, live_off.size() - 1);
            send_request(KIND_FREE, 15'(live_size[idx]), 14'(live_off[idx]));
            live_off.delete(idx);
            live_size.delete(idx);
         end else if (sel < 95) begin
            send_request(KIND_FREE, 15'($urandom), 14'($urandom));
         end else if (sel < 98) begin
            send_request(2'($urandom), 15'($urandom), 14'($urandom));
         end else begin
            send_request(KIND_REINIT, 15'($urandom), 14'($urandom));
         end
         if (i == count / 2) wait_drained();   // sender holds off until all results are in
      end
   endtask

   initial begin
      heap_reinit();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random(300);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
